### hw/rtl/bbsf_pkg.sv
`timescale 1ns / 1ps

package bbsf_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned DepthDefault    = 1024;
  localparam int unsigned MaxBurstDefault = 64;

  // Field widths.
  localparam int unsigned CapW   = 11;
  localparam int unsigned OpW    = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 7;
  localparam int unsigned TotalW = 32;

  localparam logic [CapW-1:0] CapReset = 11'd1024;
  localparam logic [CapW-1:0] CapMax   = 11'd2047;

  // Operation codes carried in s_axis_tuser.
  localparam logic [OpW-1:0] OpWrite = 3'd0;
  localparam logic [OpW-1:0] OpRead  = 3'd1;
  localparam logic [OpW-1:0] OpPeek  = 3'd2;
  localparam logic [OpW-1:0] OpPop   = 3'd3;
  localparam logic [OpW-1:0] OpEnd   = 3'd4;

  // Packed stream widths, padded to whole bytes.
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 104;

endpackage

### hw/rtl/bbsf_ram.sv
`timescale 1ns / 1ps

module bbsf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // Read data holds while the read enable is low.
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/bounded_byte_stream_fifo.sv
`timescale 1ns / 1ps

// Channel     Direction  Handshake                    Payload
// s_axis      in         s_axis_tvalid/s_axis_tready  tdata {count, wr_data}, tuser op
// m_axis      out        m_axis_tvalid/m_axis_tready  tdata status and byte, tuser data_valid,
//                                                      tlast last
// cfg         in         cfg_valid_i/cfg_ready_o      cfg_data_i capacity
//
// Write, pop, end-input and unknown operations each give one result. A read or peek gives
// one result per byte, the count capped at MAX_BURST and the bytes held (one result when
// none is held); the ring's single read port gives one byte per cycle unless m_axis stalls.
// The next transaction is taken in the cycle the last result of the previous one is taken.
// Reset is asynchronous and active low; it empties the buffer and sets capacity to 1024.
// A stalled m_axis holds the result and pauses the memory reads; s_axis is then not ready.

module bounded_byte_stream_fifo
  import bbsf_pkg::*;
#(
  parameter int unsigned DEPTH     = DepthDefault,
  parameter int unsigned MAX_BURST = MaxBurstDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] wr_data, [14:8] count, [15] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [2:0] op
  input  logic [OpW-1:0]      s_axis_tuser,

  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] rd_data, [8] accepted, [19:9] occupancy, [30:20] room_left,
  // [62:31] total_written, [94:63] total_read, [95] ended, [96] at_eof, [103:97] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // [0] data_valid
  output logic [0:0]          m_axis_tuser,
  output logic                m_axis_tlast,

  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CapW-1:0]     cfg_data_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Width of head plus offset before the ring wrap.
  localparam int unsigned PW = ((AW > CapW) ? AW : CapW) + 1;
  localparam logic [CapW-1:0]   DepthCap = (DEPTH > CapMax) ? CapMax : CapW'(DEPTH);
  localparam logic [CountW-1:0] BurstCap = CountW'(MAX_BURST);
  localparam logic [AW-1:0]     LastAddr = AW'(DEPTH - 1);
  localparam logic [PW-1:0]     DepthP   = PW'(DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } state_e;

  state_e            state_q;
  logic              m_valid_q;
  logic              dv_q;
  logic              last_q;
  logic              acc_q;
  logic [AW-1:0]     head_q;
  logic [CapW-1:0]   fill_q;
  logic [TotalW-1:0] wr_total_q;
  logic [TotalW-1:0] rd_total_q;
  logic              done_q;
  logic [CapW-1:0]   cap_q;
  logic [AW-1:0]     addr_q;
  logic [CountW-1:0] rem_q;

  logic [OpW-1:0]    op;
  logic [ByteW-1:0]  wr_data;
  logic [CountW-1:0] count;
  logic [CountW-1:0] cnt_capped;
  logic [CountW-1:0] n_bytes;
  logic [CapW-1:0]   eff_cap;
  logic              wr_ok;
  logic              out_free;
  logic              s_acc;
  logic              burst_re;
  logic              is_rdpk;
  logic [PW-1:0]     wpos_sum;
  logic [PW-1:0]     head_sum;
  logic [AW-1:0]     wpos;
  logic [AW-1:0]     head_new;
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [ByteW-1:0]  ram_rdata;
  logic [CapW-1:0]   room_left;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
    ring_inc = (a == LastAddr) ? '0 : a + AW'(1);
  endfunction

  assign op      = s_axis_tuser;
  assign wr_data = s_axis_tdata[7:0];
  assign count   = s_axis_tdata[14:8];

  assign eff_cap    = (cap_q > DepthCap) ? DepthCap : cap_q;
  assign cnt_capped = (count > BurstCap) ? BurstCap : count;
  assign n_bytes    = ({{(CapW-CountW){1'b0}}, cnt_capped} < fill_q) ? cnt_capped
                                                                      : CountW'(fill_q);
  assign wr_ok      = !done_q && (fill_q < eff_cap);
  assign is_rdpk    = (op == OpRead) || (op == OpPeek);

  // Ring positions: head plus an offset of at most DEPTH wraps with one subtraction.
  assign wpos_sum = PW'(head_q) + PW'(fill_q);
  assign head_sum = PW'(head_q) + PW'(n_bytes);
  assign wpos     = (wpos_sum >= DepthP) ? AW'(wpos_sum - DepthP) : AW'(wpos_sum);
  assign head_new = (head_sum >= DepthP) ? AW'(head_sum - DepthP) : AW'(head_sum);

  // The output register can take a new result when empty or being drained.
  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign burst_re      = (state_q == ST_BURST) && out_free;

  // The first byte of a read or peek is fetched in the accept cycle from the old head.
  assign ram_we    = s_acc && (op == OpWrite) && wr_ok;
  assign ram_re    = (s_acc && is_rdpk && (n_bytes != '0)) || burst_re;
  assign ram_raddr = s_acc ? head_q : addr_q;

  bbsf_ram #(
    .WIDTH (ByteW),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wpos),
    .wdata_i (wr_data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      m_valid_q  <= 1'b0;
      dv_q       <= 1'b0;
      last_q     <= 1'b0;
      acc_q      <= 1'b0;
      head_q     <= '0;
      fill_q     <= '0;
      wr_total_q <= '0;
      rd_total_q <= '0;
      done_q     <= 1'b0;
      cap_q      <= CapReset;
      addr_q     <= '0;
      rem_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (s_acc) begin
        m_valid_q <= 1'b1;
        dv_q      <= 1'b0;
        last_q    <= 1'b1;
        acc_q     <= 1'b0;
        case (op)
          OpWrite: begin
            if (wr_ok) begin
              fill_q     <= fill_q + CapW'(1);
              wr_total_q <= wr_total_q + TotalW'(1);
              acc_q      <= 1'b1;
            end
          end
          OpRead, OpPeek: begin
            if (n_bytes != '0) begin
              dv_q   <= 1'b1;
              last_q <= (n_bytes == CountW'(1));
              addr_q <= ring_inc(head_q);
              rem_q  <= n_bytes - CountW'(1);
              if (n_bytes != CountW'(1)) begin
                state_q <= ST_BURST;
              end
            end
            // The state after the whole read is settled now, so every result of
            // the burst reports it.
            if (op == OpRead) begin
              head_q     <= head_new;
              fill_q     <= fill_q - CapW'(n_bytes);
              rd_total_q <= rd_total_q + TotalW'(n_bytes);
            end
          end
          OpPop: begin
            head_q     <= head_new;
            fill_q     <= fill_q - CapW'(n_bytes);
            rd_total_q <= rd_total_q + TotalW'(n_bytes);
          end
          OpEnd: begin
            done_q <= 1'b1;
          end
          default: begin
          end
        endcase
      end else if (burst_re) begin
        m_valid_q <= 1'b1;
        dv_q      <= 1'b1;
        acc_q     <= 1'b0;
        last_q    <= (rem_q == CountW'(1));
        addr_q    <= ring_inc(addr_q);
        rem_q     <= rem_q - CountW'(1);
        if (rem_q == CountW'(1)) begin
          state_q <= ST_IDLE;
        end
      end
    end
  end

  // Status comes straight from the state registers, which already hold the state
  // after the item whose results are on the port.
  assign room_left = (eff_cap > fill_q) ? (eff_cap - fill_q) : '0;

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = dv_q;
  assign m_axis_tdata  = {
    7'd0,
    done_q && (fill_q == '0),
    done_q,
    rd_total_q,
    wr_total_q,
    room_left,
    fill_q,
    acc_q,
    dv_q ? ram_rdata : 8'd0
  };

endmodule
